@@ design/tpd_pkg.sv @@
package tpd_pkg;

	// frame format select
	typedef enum logic {
		MODE_FIVE_BYTE = 1'b0,
		MODE_TEN_BYTE  = 1'b1
	} proto_mode_t;

	// button tracker states, as reported on button_event
	typedef enum logic [1:0] {
		BTN_IDLE     = 2'd0,
		BTN_PRESSED  = 2'd1,
		BTN_HELD     = 2'd2,
		BTN_RELEASED = 2'd3
	} btn_state_t;

	// configuration register indexes
	localparam logic [2:0] REG_PROTOCOL_MODE = 3'd0;
	localparam logic [2:0] REG_X_GAIN        = 3'd1;
	localparam logic [2:0] REG_Y_GAIN        = 3'd2;
	localparam logic [2:0] REG_X_OFFSET      = 3'd3;
	localparam logic [2:0] REG_Y_OFFSET      = 3'd4;

	// framing bytes
	localparam logic [7:0] SYNC_BIT_MASK = 8'h80;
	localparam logic [7:0] HDR_BYTE0     = 8'h55;
	localparam logic [7:0] HDR_BYTE1     = 8'h54;
	localparam logic [7:0] TOUCH_MASK    = 8'h01;

	// frame positions
	localparam logic [3:0] POS_HUNT      = 4'd0;
	localparam logic [3:0] POS_HDR1      = 4'd1;
	localparam logic [3:0] POS_FIVE_LAST = 4'd4;
	localparam logic [3:0] POS_TEN_LAST  = 4'd9;

	// reset values
	localparam logic signed [15:0] GAIN_UNITY = 16'sd256;

endpackage

@@ design/touch_packet_decoder_core.sv @@
// A word that completes a frame gives its result on out_valid through stage 1 (decoded
// fields), stage 2 (gain multiply) and the output register (scale and saturate). One word
// per cycle unless out_ready stalls; the two coordinate multipliers are fully pipelined.
// Reset (arst_n low, asynchronous): frame hunting, tracker idle, gains unity, offsets zero,
// five-byte mode, pipeline empty. Frame byte store is not reset.
module touch_packet_decoder_core #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int COORD_WIDTH    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// configuration port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] cal_x,
	output logic signed [15:0] cal_y,
	output logic [15:0]        raw_x,
	output logic [15:0]        raw_y,
	output logic [15:0]        raw_pressure,
	output logic [1:0]         button_event,
	output logic [7:0]         status_byte
);

	localparam int DIFF_W = 18;
	localparam int PROD_W = DIFF_W + 16;
	localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'sd1 <<< GAIN_FRAC_BITS) - 1);
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

	// configuration registers
	tpd_pkg::proto_mode_t    mode_q;
	logic signed [15:0]      x_gain_q, y_gain_q, x_off_q, y_off_q;

	// framing state
	logic [3:0]              pos_q, pos_d;
	logic [7:0]              fb_q [8];
	tpd_pkg::btn_state_t     btn_q, btn_d;

	logic                    in_acc;
	logic                    fb_we;
	logic [2:0]              fb_idx;
	logic                    frame_done;
	logic [15:0]             rx_c, ry_c, press_c;
	logic [7:0]              status_c;
	logic [1:0]              btn_out_c;
	logic signed [DIFF_W-1:0] diff_x_c, diff_y_c;

	// pipeline
	logic                    valid_s1, valid_s2, out_valid_q;
	logic                    s1_load, s2_load, out_load;
	logic [15:0]             raw_x_s1, raw_y_s1, press_s1;
	logic [7:0]              status_s1;
	logic [1:0]              btn_s1;
	logic signed [DIFF_W-1:0] diff_x_s1, diff_y_s1;
	logic [15:0]             raw_x_s2, raw_y_s2, press_s2;
	logic [7:0]              status_s2;
	logic [1:0]              btn_s2;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2;
	logic signed [15:0]      cal_x_q, cal_y_q;
	logic [15:0]             raw_x_q, raw_y_q, press_q;
	logic [7:0]              status_q;
	logic [1:0]              btn_out_q;

	// truncate toward zero, then clamp to the coordinate range
	function automatic logic signed [15:0] scale_sat(input logic signed [PROD_W-1:0] prod);
		logic signed [PROD_W-1:0] biased;
		logic signed [PROD_W-1:0] q;
		biased = prod + (prod[PROD_W-1] ? TRUNC_BIAS : '0);
		q = biased >>> GAIN_FRAC_BITS;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return q[15:0];
	endfunction

	// flow control: each stage loads when it is empty or the next one moves
	assign out_load = !out_valid_q || out_ready;
	assign s2_load  = !valid_s2 || out_load;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_ready = s1_load;
	assign in_acc   = in_valid && in_ready;

	// configuration writes; zero gains are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tpd_pkg::MODE_FIVE_BYTE;
			x_gain_q <= tpd_pkg::GAIN_UNITY;
			y_gain_q <= tpd_pkg::GAIN_UNITY;
			x_off_q  <= '0;
			y_off_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpd_pkg::REG_PROTOCOL_MODE: mode_q <= tpd_pkg::proto_mode_t'(cfg_data[0]);
				tpd_pkg::REG_X_GAIN: begin
					if (cfg_data != '0) x_gain_q <= $signed(cfg_data);
				end
				tpd_pkg::REG_Y_GAIN: begin
					if (cfg_data != '0) y_gain_q <= $signed(cfg_data);
				end
				tpd_pkg::REG_X_OFFSET: x_off_q <= $signed(cfg_data);
				tpd_pkg::REG_Y_OFFSET: y_off_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// deframer: next position, byte store write and frame completion
	always_comb begin
		pos_d      = pos_q;
		btn_d      = btn_q;
		fb_we      = 1'b0;
		fb_idx     = pos_q[2:0];
		frame_done = 1'b0;
		rx_c       = {fb_q[4], fb_q[3]};
		ry_c       = {fb_q[6], fb_q[5]};
		press_c    = {fb_q[0], fb_q[7]};
		status_c   = fb_q[2];
		btn_out_c  = tpd_pkg::BTN_IDLE;
		if (mode_q == tpd_pkg::MODE_FIVE_BYTE) begin
			press_c  = '0;
			status_c = '0;
			rx_c     = {2'b00, fb_q[1][6:0], fb_q[2][6:0]};
			ry_c     = {2'b00, fb_q[3][6:0], rx_byte[6:0]};
			if ((fb_q[0] & tpd_pkg::TOUCH_MASK) == '0) begin
				btn_d = tpd_pkg::BTN_RELEASED;
			end else if (btn_q == tpd_pkg::BTN_PRESSED) begin
				btn_d = tpd_pkg::BTN_HELD;
			end else if (btn_q == tpd_pkg::BTN_RELEASED) begin
				btn_d = tpd_pkg::BTN_PRESSED;
			end
			btn_out_c = btn_d;
			if (pos_q == tpd_pkg::POS_HUNT) begin
				if ((rx_byte & tpd_pkg::SYNC_BIT_MASK) != '0) begin
					fb_we = 1'b1;
					pos_d = 4'd1;
				end
			end else if (pos_q < tpd_pkg::POS_FIVE_LAST) begin
				fb_we = 1'b1;
				pos_d = pos_q + 4'd1;
			end else if (pos_q == tpd_pkg::POS_FIVE_LAST) begin
				frame_done = 1'b1;
				pos_d      = tpd_pkg::POS_HUNT;
			end else begin
				pos_d = tpd_pkg::POS_HUNT;
			end
			if (!frame_done) btn_d = btn_q;
		end else begin
			if (pos_q == tpd_pkg::POS_HUNT) begin
				pos_d = (rx_byte == tpd_pkg::HDR_BYTE0) ? 4'd1 : tpd_pkg::POS_HUNT;
			end else if (pos_q == tpd_pkg::POS_HDR1) begin
				pos_d = (rx_byte == tpd_pkg::HDR_BYTE1) ? 4'd2 : tpd_pkg::POS_HUNT;
			end else if (pos_q < tpd_pkg::POS_TEN_LAST) begin
				fb_we = 1'b1;
				pos_d = pos_q + 4'd1;
			end else if (pos_q == tpd_pkg::POS_TEN_LAST) begin
				frame_done = 1'b1;
				pos_d      = tpd_pkg::POS_HUNT;
			end else begin
				pos_d = tpd_pkg::POS_HUNT;
			end
		end
	end

	// raw minus offset, signed
	assign diff_x_c = $signed({2'b00, rx_c}) - DIFF_W'(x_off_q);
	assign diff_y_c = $signed({2'b00, ry_c}) - DIFF_W'(y_off_q);

	// framing state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= tpd_pkg::POS_HUNT;
			btn_q <= tpd_pkg::BTN_IDLE;
		end else if (in_acc) begin
			pos_q <= pos_d;
			btn_q <= btn_d;
		end
	end

	// frame byte store
	always_ff @(posedge clk) begin
		if (in_acc && fb_we) begin
			fb_q[fb_idx] <= rx_byte;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load)  valid_s1    <= in_acc && frame_done;
			if (s2_load)  valid_s2    <= valid_s1;
			if (out_load) out_valid_q <= valid_s2;
		end
	end

	// stage 1: decoded frame fields
	always_ff @(posedge clk) begin
		if (s1_load) begin
			raw_x_s1  <= rx_c;
			raw_y_s1  <= ry_c;
			press_s1  <= press_c;
			status_s1 <= status_c;
			btn_s1    <= btn_out_c;
			diff_x_s1 <= diff_x_c;
			diff_y_s1 <= diff_y_c;
		end
	end

	// stage 2: gain multiply
	always_ff @(posedge clk) begin
		if (s2_load) begin
			prod_x_s2 <= PROD_W'(diff_x_s1) * PROD_W'(x_gain_q);
			prod_y_s2 <= PROD_W'(diff_y_s1) * PROD_W'(y_gain_q);
			raw_x_s2  <= raw_x_s1;
			raw_y_s2  <= raw_y_s1;
			press_s2  <= press_s1;
			status_s2 <= status_s1;
			btn_s2    <= btn_s1;
		end
	end

	// output register: scale and saturate
	always_ff @(posedge clk) begin
		if (out_load) begin
			cal_x_q   <= scale_sat(prod_x_s2);
			cal_y_q   <= scale_sat(prod_y_s2);
			raw_x_q   <= raw_x_s2;
			raw_y_q   <= raw_y_s2;
			press_q   <= press_s2;
			status_q  <= status_s2;
			btn_out_q <= btn_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign cal_x        = cal_x_q;
	assign cal_y        = cal_y_q;
	assign raw_x        = raw_x_q;
	assign raw_y        = raw_y_q;
	assign raw_pressure = press_q;
	assign button_event = btn_out_q;
	assign status_byte  = status_q;

endmodule
